@@ rtl/diagonal_emboss_filter_assert.svh @@
// assertion macros for the diagonal emboss filter checker
`ifndef DIAGONAL_EMBOSS_FILTER_ASSERT_SVH
`define DIAGONAL_EMBOSS_FILTER_ASSERT_SVH

// same-cycle implication
`define DEF_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("emboss filter check failed");

// next-cycle implication
`define DEF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("emboss filter check failed");

`endif

@@ rtl/def_pkg.sv @@
// shared constants and types of the diagonal emboss filter
package def_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int CH_W   = 8;
   localparam int PIX_W  = 3 * CH_W;
   localparam int POS_W  = 11;
   localparam int CFG_W  = 12;
   localparam int ADDR_W = 2;

   localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [ADDR_W-1:0] REG_EFFECT_OFFSET  = 2'd1;
   localparam logic [ADDR_W-1:0] REG_DIRECTION_MODE = 2'd2;

   localparam logic MODE_RELIEVO = 1'b0;
   localparam logic MODE_CARVE   = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd2048;
   localparam logic [CH_W-1:0]  OFFSET_RST = 8'd128;

   typedef struct packed {
      logic [CFG_W-1:0] image_width;
      logic [CH_W-1:0]  effect_offset;
      logic             direction_mode;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [CH_W-1:0]  c2;
      logic [CH_W-1:0]  c1;
      logic [CH_W-1:0]  c0;
      logic             valid;
   } res_type;

endpackage

@@ rtl/def_line_ram.sv @@
// single-port read-first line store with registered read data
module def_line_ram #(
   parameter int DEPTH  = def_pkg::MAX_WIDTH_DEF,
   parameter int DATA_W = def_pkg::PIX_W
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);
   logic [DATA_W-1:0] line_mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         rdata_ff       <= line_mem[addr];
         line_mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/def_datapath.sv @@
// position counters, line store access and per-channel emboss arithmetic
module def_datapath #(
   parameter int MAX_WIDTH  = def_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = def_pkg::MAX_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [def_pkg::PIX_W-1:0] pixel,
   input  logic                     frame_start,
   input  def_pkg::cfg_type         cfg,
   output def_pkg::res_type         result
);
   import def_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);
   localparam logic [WW-1:0] W_MIN    = WW'(2);
   localparam logic [WW-1:0] W_MAX    = WW'(MAX_WIDTH);

   logic [CW-1:0]    col_ff, col_in, col_start, col_cur;
   logic [RW-1:0]    row_ff, row_in, row_start, row_cur;
   logic [WW-1:0]    width, col_next;
   logic             wrap_pre, wrap_post, border;
   logic [PIX_W-1:0] ul;

   function automatic logic [CH_W-1:0] emboss(
      input logic [CH_W-1:0] cur,
      input logic [CH_W-1:0] up,
      input logic [CH_W-1:0] off,
      input logic            mode
   );
      logic signed [CH_W+1:0] diff;
      logic signed [CH_W+1:0] sum;
      if (mode == MODE_CARVE) begin
         diff = $signed({2'b00, up}) - $signed({2'b00, cur});
      end else begin
         diff = $signed({2'b00, cur}) - $signed({2'b00, up});
      end
      sum = diff + $signed({2'b00, off});
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, {CH_W{1'b1}}})) begin
         return {CH_W{1'b1}};
      end else begin
         return sum[CH_W-1:0];
      end
   endfunction

   // effective row length
   always_comb begin
      if (32'(cfg.image_width) < 32'd2) begin
         width = W_MIN;
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         width = W_MAX;
      end else begin
         width = WW'(cfg.image_width);
      end
   end

   always_comb begin
      col_start = frame_start ? '0 : col_ff;
      row_start = frame_start ? '0 : row_ff;
      // width may have shrunk since the last beat
      wrap_pre  = WW'(col_start) >= width;
      col_cur   = wrap_pre ? '0 : col_start;
      row_cur   = (wrap_pre && row_start != ROW_LAST) ? row_start + 1'b1 : row_start;
      col_next  = WW'(col_cur) + 1'b1;
      wrap_post = col_next >= width;
      col_in    = wrap_post ? '0 : col_next[CW-1:0];
      row_in    = (wrap_post && row_cur != ROW_LAST) ? row_cur + 1'b1 : row_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // read data of this beat is the upper-left pixel of the next beat
   def_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIX_W)
   ) u_line_ram (
      .clock  (clock),
      .enable (accept),
      .addr   (col_cur),
      .wdata  (pixel),
      .rdata  (ul)
   );

   always_comb begin
      border       = (row_cur == '0) || (col_cur == '0);
      result.valid = !border;
      if (border) begin
         result.c0  = '0;
         result.c1  = '0;
         result.c2  = '0;
         result.col = POS_W'(col_cur);
         result.row = POS_W'(row_cur);
      end else begin
         result.c0 = emboss(pixel[CH_W-1:0], ul[CH_W-1:0],
                            cfg.effect_offset, cfg.direction_mode);
         result.c1 = emboss(pixel[2*CH_W-1:CH_W], ul[2*CH_W-1:CH_W],
                            cfg.effect_offset, cfg.direction_mode);
         result.c2 = emboss(pixel[3*CH_W-1:2*CH_W], ul[3*CH_W-1:2*CH_W],
                            cfg.effect_offset, cfg.direction_mode);
         if (cfg.direction_mode == MODE_CARVE) begin
            result.col = POS_W'(col_cur - 1'b1);
            result.row = POS_W'(row_cur - 1'b1);
         end else begin
            result.col = POS_W'(col_cur);
            result.row = POS_W'(row_cur);
         end
      end
   end

endmodule

@@ rtl/def_out_buf.sv @@
// two-entry output buffer: main register plus skid register
module def_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  def_pkg::res_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output def_pkg::res_type out_data
);
   import def_pkg::*;

   res_type main_ff, main_in, skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic    pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ rtl/diagonal_emboss_filter.sv @@
// diagonal emboss filter top level
// Takes one pixel beat per clock while req_tready is high and returns one registered
// result beat per pixel. The rate is set by the single-port line store, which is read
// and written at the current column in the same cycle (read-first); its registered read
// data is the upper-left pixel of the following beat. A two-entry output buffer takes
// one more input beat while a result waits on rsp_tready; after that req_tready stays
// low until the cycle after the waiting result is taken. The line store has no reset:
// pixels of a row above that was never written give undefined channel values. Configuration
// must be written only while the filter is idle; the filter does not enforce it.
module diagonal_emboss_filter #(
   parameter int MAX_WIDTH  = def_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = def_pkg::MAX_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // in_c0, in_c1, in_c2
   input  logic                       req_tuser,  // frame_start
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,  // out_c0, out_c1, out_c2, out_col, out_row
   output logic                       rsp_tuser,  // out_valid
   input  logic                       csr_we,
   input  logic [def_pkg::ADDR_W-1:0] csr_addr,
   input  logic [def_pkg::CFG_W-1:0]  csr_wdata
);
   import def_pkg::*;

   cfg_type cfg_ff;
   res_type result, out_res;
   logic    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= WIDTH_RST;
         cfg_ff.effect_offset  <= OFFSET_RST;
         cfg_ff.direction_mode <= MODE_RELIEVO;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:    cfg_ff.image_width    <= csr_wdata;
            REG_EFFECT_OFFSET:  cfg_ff.effect_offset  <= csr_wdata[CH_W-1:0];
            REG_DIRECTION_MODE: cfg_ff.direction_mode <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   def_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_tdata),
      .frame_start (req_tuser),
      .cfg         (cfg_ff),
      .result      (result)
   );

   def_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_res)
   );

   assign rsp_tdata = {2'b00, out_res.row, out_res.col, out_res.c2, out_res.c1, out_res.c0};
   assign rsp_tuser = out_res.valid;

endmodule

@@ rtl/def_checker.sv @@
// port-level checks of the diagonal emboss filter, bound to the top level
`include "diagonal_emboss_filter_assert.svh"

module def_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   `DEF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `DEF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready,
                    $stable(rsp_tdata) && $stable(rsp_tuser))
   `DEF_ASSERT_NOW(a_border_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                   rsp_tdata[23:0] == 24'd0)
   `DEF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `DEF_ASSERT_NEXT(a_frame_origin, clock, reset,
                    req_tvalid && req_tready && req_tuser && !rsp_tvalid,
                    rsp_tvalid && !rsp_tuser && rsp_tdata[45:24] == 22'd0)

endmodule

bind diagonal_emboss_filter def_checker u_def_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
